// ===== sv/assert_macros.svh =====
// Assertion helper macros shared by the RTL of the decimal text converter.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define ASSERT_HOLD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sidtoa_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the default width, the character width, the queue depth and the ASCII codes; no dependencies.
`timescale 1ns / 1ps

package sidtoa_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int CHAR_BITS          = 8;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

endpackage

// ===== sv/sidtoa_front.sv =====
// Front end: accepts input transactions and splits each value into sign and magnitude.
// Depends on sidtoa_pkg; feeds the job queue.
`timescale 1ns / 1ps

module sidtoa_front #(
    parameter int VALUE_BITS = sidtoa_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_push,
    input  logic                  i_space,
    output logic [VALUE_BITS:0]   o_job
);
    import sidtoa_pkg::*;

    logic                  w_neg;
    logic [VALUE_BITS-1:0] w_mag;

    assign w_neg   = i_value[VALUE_BITS-1];
    assign w_mag   = w_neg ? (~i_value + VALUE_BITS'(1)) : i_value;
    assign o_ready = i_space;
    assign o_push  = i_valid && i_space;
    assign o_job   = {w_neg, w_mag};

endmodule

// ===== sv/sidtoa_queue.sv =====
// Short job queue between the front end and the conversion engine.
// Depends on assert_macros.svh and sidtoa_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidtoa_queue #(
    parameter int WIDTH = sidtoa_pkg::DEFAULT_VALUE_BITS + 1,
    parameter int DEPTH = sidtoa_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import sidtoa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push, w_do_pop;

    assign o_space   = (r_count < CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && o_space;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count overflow")
    `ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_do_push && !w_do_pop, r_count == $past(r_count) + CW'(1), "queue count missed push")
    `ASSERT_NEXT(a_count_down, i_clk, i_rst_n, w_do_pop && !w_do_push, r_count == $past(r_count) - CW'(1), "queue count missed pop")

endmodule

// ===== sv/sidtoa_back.sv =====
// Conversion engine: serial double-dabble binary to BCD, then character emission.
// Depends on assert_macros.svh and sidtoa_pkg; drains the job queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidtoa_back #(
    parameter int VALUE_BITS = sidtoa_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  logic [VALUE_BITS:0]                  i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [sidtoa_pkg::CHAR_BITS-1:0]     o_char,
    output logic                                 o_last
);
    import sidtoa_pkg::*;

    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int IW   = $clog2(NDIG);
    localparam int LW   = $clog2(NDIG + 1);
    localparam int CW   = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_SIGN, S_DIGIT} t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_bits, n_bits;
    logic                  r_neg, n_neg;
    logic [3:0]            r_bcd [NDIG];
    logic [3:0]            n_bcd [NDIG];
    logic [3:0]            w_adj [NDIG];
    logic [3:0]            w_dab [NDIG];
    logic [LW-1:0]         r_len, n_len;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char, n_out_char;
    logic                  r_out_last, n_out_last;
    logic                  w_out_free, w_grow;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid    = r_out_valid;
    assign o_char     = r_out_char;
    assign o_last     = r_out_last;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[d] = (r_bcd[d] >= 4'd5) ? (r_bcd[d] + 4'd3) : r_bcd[d];
        end
        w_dab[0] = {w_adj[0][2:0], r_bits[VALUE_BITS-1]};
        for (int d = 1; d < NDIG; d++) begin
            w_dab[d] = {w_adj[d][2:0], w_adj[d-1][3]};
        end
        w_grow = (r_len < LW'(NDIG)) && (w_dab[r_len[IW-1:0]] != 4'd0);
    end

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_neg       = r_neg;
        n_bcd       = r_bcd;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_neg  = i_q_data[VALUE_BITS];
                    n_bits = i_q_data[VALUE_BITS-1:0];
                    for (int d = 0; d < NDIG; d++) begin
                        n_bcd[d] = 4'd0;
                    end
                    n_len   = LW'(1);
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bits = r_bits << 1;
                n_bcd  = w_dab;
                n_len  = r_len + LW'(w_grow);
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(VALUE_BITS - 1)) begin
                    n_idx   = IW'(n_len - LW'(1));
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CHAR_ZERO | {4'b0000, r_bcd[r_idx]};
                    n_out_last  = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_len       <= LW'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
        end
        r_bits     <= n_bits;
        r_neg      <= n_neg;
        r_bcd      <= n_bcd;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    `ASSERT_HOLD(a_len_range, i_clk, i_rst_n, (r_len >= LW'(1)) && (r_len <= LW'(NDIG)), "digit count out of range")
    `ASSERT_IMPL(a_idx_in_len, i_clk, i_rst_n, r_state == S_DIGIT, LW'(r_idx) < r_len, "digit index beyond significant digits")
    `ASSERT_NEXT(a_sign_out, i_clk, i_rst_n, (r_state == S_SIGN) && w_out_free, o_valid && !o_last && (o_char == CHAR_MINUS), "minus sign not emitted")

endmodule

// ===== sv/signed_integer_to_decimal_ascii.sv =====
// The engine pops an item from the queue and runs the one-bit-per-cycle double-dabble loop,
// then emits 1 to 11 characters at 32 bits, one character per cycle while the output is ready:
//   an optional minus sign, then the digits, most significant first.
// A two-entry queue lets the input side take new items while a conversion runs.
// Reset (synchronous, active low) empties the queue and idles the engine.
`timescale 1ns / 1ps

module signed_integer_to_decimal_ascii #(
    parameter int VALUE_BITS = sidtoa_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,  // value
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [sidtoa_pkg::CHAR_BITS-1:0]       m_axis_tdata,  // character
    output logic                                   m_axis_tlast
);
    import sidtoa_pkg::*;

    logic                  w_push, w_space, w_q_valid, w_pop;
    logic [VALUE_BITS:0]   w_job, w_q_data;

    sidtoa_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_value (s_axis_tdata[VALUE_BITS-1:0]),
        .o_push  (w_push),
        .i_space (w_space),
        .o_job   (w_job)
    );

    sidtoa_queue #(
        .WIDTH (VALUE_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    sidtoa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule
